/* rtl/core/crast_pkg.sv */
// Package for the circle rasterizer: field widths, stream packing offsets and opcodes.
// Used by circle_rasterizer; depends on nothing else.
`default_nettype none

package crast_pkg;

    // Base widths of the geometry
    localparam int COORD_WIDTH  = 12;
    localparam int RADIUS_WIDTH = 11;
    localparam int COLOR_WIDTH  = 24;

    // Result coordinates carry two extra bits for sign and overflow past the edge
    localparam int OUT_W  = COORD_WIDTH + 2;
    // Decision variable and its wider working copy
    localparam int DEC_W  = RADIUS_WIDTH + 3;
    localparam int CALC_W = RADIUS_WIDTH + 4;
    // Coordinate adder width, wide enough for either operand before truncation
    localparam int SUM_W  = ((OUT_W > RADIUS_WIDTH + 2) ? OUT_W : RADIUS_WIDTH + 2) + 1;

    // Results per step and the emit index
    localparam int MAX_RESULTS = 8;
    localparam int IDX_W       = $clog2(MAX_RESULTS);
    localparam logic [IDX_W-1:0] LAST_OUTLINE = IDX_W'(MAX_RESULTS - 1);
    localparam logic [IDX_W-1:0] LAST_FILLED  = IDX_W'(MAX_RESULTS / 2 - 1);

    // Input tdata layout, lowest bits first
    localparam int IN_CX_LO    = 0;
    localparam int IN_CY_LO    = IN_CX_LO + COORD_WIDTH;
    localparam int IN_RAD_LO   = IN_CY_LO + COORD_WIDTH;
    localparam int IN_FILL_LO  = IN_RAD_LO + RADIUS_WIDTH;
    localparam int IN_COLOR_LO = IN_FILL_LO + 1;
    localparam int IN_BITS     = IN_COLOR_LO + COLOR_WIDTH;
    localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;

    // Output tdata layout, lowest bits first
    localparam int OUT_BITS   = 3 * OUT_W + COLOR_WIDTH;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Request opcodes
    typedef enum logic {
        OP_START = 1'b0,
        OP_CONT  = 1'b1
    } t_opcode;

endpackage : crast_pkg

`default_nettype wire

/* rtl/core/circle_rasterizer.sv */
// Andres circle rasterizer: steps a circle per request and streams points or spans.
// Depends on crast_pkg for widths, packing offsets and opcodes.
`default_nettype none

// Channel  Dir  Fields (tdata/tuser, low bit first)
// -------  ---  ----------------------------------------------------------------
// s        in   tdata: center_x, center_y, radius, filled, color; tuser: opcode
// m        out  tdata: x_start, x_end, row, color_out; tuser: circle_done;
//               tlast: last_of_step
//
// A step request is stored in the step buffer and its results leave one per cycle
// from the output register while the m side is ready: 8 results per step in outline
// mode, 4 in filled mode. The next request is taken in the cycle that the previous
// step's last result moves into the output register. A continue request while idle
// yields no results. Reset (i_rst_n low, synchronous) leaves the block idle with both
// channels empty. A stall on the m side holds the output register and, while a step
// is pending in the step buffer, backs up into o_s_tready.
module circle_rasterizer
    import crast_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // request channel
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,   // center_x, center_y, radius, filled, color
    input  wire logic [0:0]            i_s_tuser,   // opcode
    // result channel
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0]      o_m_tdata,   // x_start, x_end, row, color_out
    output logic [0:0]                 o_m_tuser,   // circle_done
    output logic                       o_m_tlast    // last_of_step
);

    // ---------------------------------------------------------------
    // Request fields
    // ---------------------------------------------------------------
    t_opcode                  w_op;
    logic [COORD_WIDTH-1:0]   w_in_cx;
    logic [COORD_WIDTH-1:0]   w_in_cy;
    logic [RADIUS_WIDTH-1:0]  w_in_rad;
    logic                     w_in_fill;
    logic [COLOR_WIDTH-1:0]   w_in_color;

    assign w_op       = t_opcode'(i_s_tuser[0]);
    assign w_in_cx    = i_s_tdata[IN_CX_LO    +: COORD_WIDTH];
    assign w_in_cy    = i_s_tdata[IN_CY_LO    +: COORD_WIDTH];
    assign w_in_rad   = i_s_tdata[IN_RAD_LO   +: RADIUS_WIDTH];
    assign w_in_fill  = i_s_tdata[IN_FILL_LO];
    assign w_in_color = i_s_tdata[IN_COLOR_LO +: COLOR_WIDTH];

    // ---------------------------------------------------------------
    // Circle state
    // ---------------------------------------------------------------
    logic                       r_busy;
    logic [COORD_WIDTH-1:0]     r_cx;
    logic [COORD_WIDTH-1:0]     r_cy;
    logic [RADIUS_WIDTH-1:0]    r_rad;
    logic [RADIUS_WIDTH-1:0]    r_dx;
    logic signed [RADIUS_WIDTH:0] r_dy;
    logic signed [DEC_W-1:0]    r_dec;
    logic                       r_fill;
    logic [COLOR_WIDTH-1:0]     r_color;

    // Step being emitted: offsets before the update, and the end-of-circle flag
    logic                       r_sb_valid;
    logic [IDX_W-1:0]           r_idx;
    logic [RADIUS_WIDTH-1:0]    r_em_dx;
    logic signed [RADIUS_WIDTH:0] r_em_dy;
    logic                       r_em_done;

    // Handshake terms
    logic w_in_acc;
    logic w_run;
    logic w_start;
    logic w_load_out;
    logic w_sb_free;
    logic [IDX_W-1:0] w_last_idx;

    assign w_last_idx = r_fill ? LAST_FILLED : LAST_OUTLINE;
    assign w_load_out = r_sb_valid && (!o_m_tvalid || i_m_tready);
    assign w_sb_free  = w_load_out && (r_idx == w_last_idx);
    assign o_s_tready = !r_sb_valid || w_sb_free;
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_start    = w_in_acc && (w_op == OP_START);
    assign w_run      = w_start || (w_in_acc && (w_op == OP_CONT) && r_busy);

    // ---------------------------------------------------------------
    // Current offsets: fresh ones on start, else the stored ones
    // ---------------------------------------------------------------
    logic [RADIUS_WIDTH-1:0]      c_dx;
    logic signed [RADIUS_WIDTH:0] c_dy;
    logic signed [DEC_W-1:0]      c_dec;
    logic [RADIUS_WIDTH-1:0]      c_rad;

    always_comb begin
        if (w_op == OP_START) begin
            c_dx  = '0;
            c_dy  = $signed({1'b0, w_in_rad});
            c_dec = $signed({3'b000, w_in_rad}) - DEC_W'(1);
            c_rad = w_in_rad;
        end else begin
            c_dx  = r_dx;
            c_dy  = r_dy;
            c_dec = r_dec;
            c_rad = r_rad;
        end
    end

    // ---------------------------------------------------------------
    // Three-way decision update
    // ---------------------------------------------------------------
    logic signed [CALC_W-1:0] w_d;
    logic signed [CALC_W-1:0] w_x;
    logic signed [CALC_W-1:0] w_y;
    logic signed [CALC_W-1:0] w_r;
    logic signed [CALC_W-1:0] w_nd;
    logic signed [CALC_W-1:0] w_nx;
    logic signed [CALC_W-1:0] w_ny;
    logic                     w_done;

    assign w_d = $signed({c_dec[DEC_W-1], c_dec});
    assign w_x = $signed({4'b0000, c_dx});
    assign w_y = $signed({{3{c_dy[RADIUS_WIDTH]}}, c_dy});
    assign w_r = $signed({4'b0000, c_rad});

    always_comb begin
        priority if (w_d >= (w_x <<< 1)) begin
            w_nd = w_d - (w_x <<< 1) - CALC_W'(1);
            w_nx = w_x + CALC_W'(1);
            w_ny = w_y;
        end else if (w_d < ((w_r - w_y) <<< 1)) begin
            w_nd = w_d + (w_y <<< 1) - CALC_W'(1);
            w_nx = w_x;
            w_ny = w_y - CALC_W'(1);
        end else begin
            w_nd = w_d + ((w_y - w_x - CALC_W'(1)) <<< 1);
            w_nx = w_x + CALC_W'(1);
            w_ny = w_y - CALC_W'(1);
        end
    end

    assign w_done = w_ny < w_nx;

    // Circle state update on a start request and on a continue request while busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_cx    <= '0;
            r_cy    <= '0;
            r_rad   <= '0;
            r_dx    <= '0;
            r_dy    <= '0;
            r_dec   <= '0;
            r_fill  <= 1'b0;
            r_color <= '0;
        end else begin
            if (w_start) begin
                r_cx    <= w_in_cx;
                r_cy    <= w_in_cy;
                r_rad   <= w_in_rad;
                r_fill  <= w_in_fill;
                r_color <= w_in_color;
            end
            if (w_run) begin
                r_busy <= !w_done;
                r_dx   <= w_nx[RADIUS_WIDTH-1:0];
                r_dy   <= w_ny[RADIUS_WIDTH:0];
                r_dec  <= w_nd[DEC_W-1:0];
            end
        end
    end

    // Step buffer: valid flag and emit index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sb_valid <= 1'b0;
            r_idx      <= '0;
        end else begin
            if (w_run) begin
                r_sb_valid <= 1'b1;
                r_idx      <= '0;
            end else if (w_sb_free) begin
                r_sb_valid <= 1'b0;
                r_idx      <= '0;
            end else if (w_load_out) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    // Offsets of the step to emit
    always_ff @(posedge i_clk) begin
        if (w_run) begin
            r_em_dx   <= c_dx;
            r_em_dy   <= c_dy;
            r_em_done <= w_done;
        end
    end

    // ---------------------------------------------------------------
    // Result for the current emit index
    // ---------------------------------------------------------------
    logic                     w_swap;
    logic                     w_negx;
    logic                     w_negy;
    logic signed [SUM_W-1:0]  w_sdx;
    logic signed [SUM_W-1:0]  w_sdy;
    logic signed [SUM_W-1:0]  w_xo;
    logic signed [SUM_W-1:0]  w_yo;
    logic signed [SUM_W-1:0]  w_cx;
    logic signed [SUM_W-1:0]  w_cy;
    logic signed [SUM_W-1:0]  w_xs;
    logic signed [SUM_W-1:0]  w_xe;
    logic signed [SUM_W-1:0]  w_row;
    logic                     w_last;

    // Outline: bit 0 swaps the offsets, bit 1 mirrors x, bit 2 mirrors y.
    // Filled: indices 0 and 3 use the swapped offsets, bit 1 mirrors the row.
    always_comb begin
        if (r_fill) begin
            w_swap = !(r_idx[0] ^ r_idx[1]);
            w_negx = 1'b0;
            w_negy = r_idx[1];
        end else begin
            w_swap = r_idx[0];
            w_negx = r_idx[1];
            w_negy = r_idx[2];
        end
    end

    assign w_sdx = $signed(SUM_W'(r_em_dx));
    assign w_sdy = SUM_W'(r_em_dy);
    assign w_xo  = w_swap ? w_sdy : w_sdx;
    assign w_yo  = w_swap ? w_sdx : w_sdy;
    assign w_cx  = $signed(SUM_W'(r_cx));
    assign w_cy  = $signed(SUM_W'(r_cy));
    assign w_row = w_negy ? (w_cy - w_yo) : (w_cy + w_yo);

    always_comb begin
        if (r_fill) begin
            w_xs = w_cx - w_xo;
            w_xe = w_cx + w_xo;
        end else begin
            w_xs = w_negx ? (w_cx - w_xo) : (w_cx + w_xo);
            w_xe = w_xs;
        end
    end

    assign w_last = (r_idx == w_last_idx);

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
        end else if (w_load_out) begin
            o_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            o_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            o_m_tdata    <= OUT_DATA_W'({r_color, w_row[OUT_W-1:0], w_xe[OUT_W-1:0],
                                         w_xs[OUT_W-1:0]});
            o_m_tlast    <= w_last;
            o_m_tuser[0] <= w_last && r_em_done;
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // circle end is only flagged on the last result of a step
    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tlast)
        else $error("circle_done without last_of_step");

    // a pending step that does not end the circle leaves the block busy
    a_busy_mid_circle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sb_valid && !r_em_done |-> r_busy)
        else $error("step pending mid-circle while idle");

    // emitted offsets stay in the first octant
    a_octant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sb_valid |-> r_em_dy >= $signed({1'b0, r_em_dx}))
        else $error("emitted dy below dx");

    // filled steps never index past the fourth span
    a_fill_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sb_valid && r_fill |-> !r_idx[IDX_W-1])
        else $error("filled step index out of range");

    // a continue request while idle produces no step
    a_idle_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (w_op == OP_CONT) && !r_busy && !r_sb_valid |=> !r_sb_valid)
        else $error("idle continue started a step");

endmodule : circle_rasterizer

`default_nettype wire
